FILE: src/typed_handle_allocator_macros.svh
`ifndef TYPED_HANDLE_ALLOCATOR_MACROS_SVH
`define TYPED_HANDLE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define THA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define THA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tha_pkg.sv
package tha_pkg;

  localparam int SLOTS       = 64;
  localparam int TYPE_BITS   = 4;
  localparam int VALUE_BITS  = 64;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int HANDLE_W    = 7;
  localparam int REQ_W       = 3;
  localparam int SLOT_DATA_W = VALUE_BITS + TYPE_BITS;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC     = 3'd0,
    REQ_GET       = 3'd1,
    REQ_TYPED_GET = 3'd2,
    REQ_CLOSE     = 3'd3,
    REQ_CLOSE_ALL = 3'd4
  } req_t;

  typedef struct packed {
    logic                   we;
    logic [SLOT_W-1:0]      waddr;
    logic [SLOT_DATA_W-1:0] wdata;
    logic                   re;
    logic [SLOT_W-1:0]      raddr;
  } slot_port_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } stack_port_t;

endpackage

FILE: src/tha_ram.sv
module tha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/tha_ctrl.sv
module tha_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tha_pkg::REQ_W-1:0]       req_type,
  input  logic [tha_pkg::HANDLE_W-1:0]    handle,
  input  logic [tha_pkg::VALUE_BITS-1:0]  object_value,
  input  logic [tha_pkg::TYPE_BITS-1:0]   object_type,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            ok,
  output logic [tha_pkg::HANDLE_W-1:0]    handle_out,
  output logic [tha_pkg::VALUE_BITS-1:0]  object_out,
  output logic [tha_pkg::CNT_W-1:0]       closed_count,
  output tha_pkg::slot_port_t             slot_port,
  input  logic [tha_pkg::SLOT_DATA_W-1:0] slot_rdata,
  output tha_pkg::stack_port_t            stack_port,
  input  logic [tha_pkg::SLOT_W-1:0]      stack_rdata
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t                          state, state_next;
  logic [tha_pkg::REQ_W-1:0]       req_q;
  logic [tha_pkg::HANDLE_W-1:0]    handle_q;
  logic [tha_pkg::VALUE_BITS-1:0]  value_q;
  logic [tha_pkg::TYPE_BITS-1:0]   kind_q;
  logic [tha_pkg::SLOTS-1:0]       live, live_next;
  logic [tha_pkg::CNT_W-1:0]       free_depth, free_depth_next;
  logic [tha_pkg::CNT_W-1:0]       high_water, high_water_next;
  logic [tha_pkg::CNT_W-1:0]       sweep_idx, sweep_idx_next;
  logic [tha_pkg::CNT_W-1:0]       sweep_count, sweep_count_next;

  logic                            accept;
  logic                            fire;
  logic                            load;
  logic                            have;
  logic                            hit;
  logic [tha_pkg::HANDLE_W-1:0]    handle_m1;
  logic [tha_pkg::HANDLE_W-1:0]    handle_q_m1;
  logic [tha_pkg::CNT_W-1:0]       depth_m1;
  logic [tha_pkg::SLOT_W-1:0]      alloc_slot;
  logic                            res_ok;
  logic [tha_pkg::HANDLE_W-1:0]    res_handle;
  logic [tha_pkg::VALUE_BITS-1:0]  res_object;
  logic [tha_pkg::CNT_W-1:0]       res_count;

  assign in_stall    = (state != ST_IDLE);
  assign accept      = in_valid && !in_stall;
  assign fire        = !out_valid || !out_stall;
  assign handle_m1   = handle - 1'b1;
  assign handle_q_m1 = handle_q - 1'b1;
  assign depth_m1    = free_depth - 1'b1;
  assign hit         = (handle_q != '0) && (handle_q_m1 < high_water)
                       && live[handle_q_m1[tha_pkg::SLOT_W-1:0]];

  always_comb begin
    state_next       = state;
    live_next        = live;
    free_depth_next  = free_depth;
    high_water_next  = high_water;
    sweep_idx_next   = sweep_idx;
    sweep_count_next = sweep_count;
    slot_port        = '0;
    stack_port       = '0;
    load             = 1'b0;
    have             = 1'b0;
    alloc_slot       = '0;
    res_ok           = 1'b0;
    res_handle       = '0;
    res_object       = '0;
    res_count        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          slot_port.re     = 1'b1;
          slot_port.raddr  = handle_m1[tha_pkg::SLOT_W-1:0];
          stack_port.re    = 1'b1;
          stack_port.raddr = depth_m1[tha_pkg::SLOT_W-1:0];
          if (req_type == tha_pkg::REQ_CLOSE_ALL) begin
            state_next       = ST_SWEEP;
            sweep_idx_next   = '0;
            sweep_count_next = '0;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_SWEEP: begin
        if (sweep_idx < high_water) begin
          stack_port.we    = 1'b1;
          stack_port.waddr = sweep_idx[tha_pkg::SLOT_W-1:0];
          stack_port.wdata = sweep_idx[tha_pkg::SLOT_W-1:0];
          live_next[sweep_idx[tha_pkg::SLOT_W-1:0]] = 1'b0;
          sweep_count_next = sweep_count
            + {{(tha_pkg::CNT_W-1){1'b0}}, live[sweep_idx[tha_pkg::SLOT_W-1:0]]};
          sweep_idx_next   = sweep_idx + 1'b1;
        end else begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          load       = 1'b1;
          state_next = ST_IDLE;
          case (req_q)
            tha_pkg::REQ_ALLOC: begin
              if (value_q != '0) begin
                if (free_depth != '0) begin
                  alloc_slot      = stack_rdata;
                  free_depth_next = free_depth - 1'b1;
                  have            = 1'b1;
                end else if (high_water < tha_pkg::CNT_W'(tha_pkg::SLOTS)) begin
                  alloc_slot      = high_water[tha_pkg::SLOT_W-1:0];
                  high_water_next = high_water + 1'b1;
                  have            = 1'b1;
                end
              end
              if (have) begin
                slot_port.we          = 1'b1;
                slot_port.waddr       = alloc_slot;
                slot_port.wdata       = {value_q, kind_q};
                live_next[alloc_slot] = 1'b1;
                res_ok                = 1'b1;
                res_handle            = tha_pkg::HANDLE_W'(alloc_slot) + 1'b1;
              end
            end
            tha_pkg::REQ_GET, tha_pkg::REQ_TYPED_GET: begin
              if (hit && ((req_q == tha_pkg::REQ_GET)
                          || (slot_rdata[tha_pkg::TYPE_BITS-1:0] == kind_q))) begin
                res_ok     = 1'b1;
                res_object = slot_rdata[tha_pkg::SLOT_DATA_W-1:tha_pkg::TYPE_BITS];
              end
            end
            tha_pkg::REQ_CLOSE: begin
              if (hit) begin
                live_next[handle_q_m1[tha_pkg::SLOT_W-1:0]] = 1'b0;
                if (free_depth < tha_pkg::CNT_W'(tha_pkg::SLOTS)) begin
                  stack_port.we    = 1'b1;
                  stack_port.waddr = free_depth[tha_pkg::SLOT_W-1:0];
                  stack_port.wdata = handle_q_m1[tha_pkg::SLOT_W-1:0];
                  free_depth_next  = free_depth + 1'b1;
                end
                res_ok = 1'b1;
              end
            end
            tha_pkg::REQ_CLOSE_ALL: begin
              res_ok          = 1'b1;
              res_count       = sweep_count;
              free_depth_next = high_water;
            end
            default: begin
            end
          endcase
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      live        <= '0;
      free_depth  <= '0;
      high_water  <= '0;
      sweep_idx   <= '0;
      sweep_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      live        <= live_next;
      free_depth  <= free_depth_next;
      high_water  <= high_water_next;
      sweep_idx   <= sweep_idx_next;
      sweep_count <= sweep_count_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q    <= req_type;
      handle_q <= handle;
      value_q  <= object_value;
      kind_q   <= object_type;
    end
    if (load) begin
      ok           <= res_ok;
      handle_out   <= res_handle;
      object_out   <= res_object;
      closed_count <= res_count;
    end
  end

endmodule

FILE: src/typed_handle_allocator.sv
// Handle table with a LIFO free list. Ready right after reset. Alloc, get,
// typed get and close read the slot and free-stack memories (registered
// reads) in the idle state, then decide, write back and load the result
// register in the exec state. Close all first walks the free-stack memory
// one entry per cycle to reload it and count live slots. One request is in
// flight at a time; the next one is taken while the previous result still
// waits in the output register.
module typed_handle_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tha_pkg::REQ_W-1:0]      req_type,
  input  logic [tha_pkg::HANDLE_W-1:0]   handle,
  input  logic [tha_pkg::VALUE_BITS-1:0] object_value,
  input  logic [tha_pkg::TYPE_BITS-1:0]  object_type,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           ok,
  output logic [tha_pkg::HANDLE_W-1:0]   handle_out,
  output logic [tha_pkg::VALUE_BITS-1:0] object_out,
  output logic [tha_pkg::CNT_W-1:0]      closed_count
);

  tha_pkg::slot_port_t             slot_port;
  tha_pkg::stack_port_t            stack_port;
  logic [tha_pkg::SLOT_DATA_W-1:0] slot_rdata;
  logic [tha_pkg::SLOT_W-1:0]      stack_rdata;

  tha_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .handle       (handle),
    .object_value (object_value),
    .object_type  (object_type),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ok           (ok),
    .handle_out   (handle_out),
    .object_out   (object_out),
    .closed_count (closed_count),
    .slot_port    (slot_port),
    .slot_rdata   (slot_rdata),
    .stack_port   (stack_port),
    .stack_rdata  (stack_rdata)
  );

  tha_ram #(
    .WIDTH (tha_pkg::SLOT_DATA_W),
    .DEPTH (tha_pkg::SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_port.we),
    .waddr (slot_port.waddr),
    .wdata (slot_port.wdata),
    .re    (slot_port.re),
    .raddr (slot_port.raddr),
    .rdata (slot_rdata)
  );

  tha_ram #(
    .WIDTH (tha_pkg::SLOT_W),
    .DEPTH (tha_pkg::SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_port.we),
    .waddr (stack_port.waddr),
    .wdata (stack_port.wdata),
    .re    (stack_port.re),
    .raddr (stack_port.raddr),
    .rdata (stack_rdata)
  );

endmodule

FILE: src/tha_checker.sv
`include "typed_handle_allocator_macros.svh"

module tha_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [tha_pkg::REQ_W-1:0]      req_type,
  input logic [tha_pkg::HANDLE_W-1:0]   handle,
  input logic [tha_pkg::VALUE_BITS-1:0] object_value,
  input logic [tha_pkg::TYPE_BITS-1:0]  object_type,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           ok,
  input logic [tha_pkg::HANDLE_W-1:0]   handle_out,
  input logic [tha_pkg::VALUE_BITS-1:0] object_out,
  input logic [tha_pkg::CNT_W-1:0]      closed_count
);

  // one request in flight: a transfer in closes the input behind it
  `THA_ASSERT_NEXT(a_in_busy, clk, rst, in_valid && !in_stall, in_stall, "input open after transfer")

  `THA_ASSERT_IMPLY(a_fail_zero, clk, rst, out_valid && !ok, handle_out == '0 && object_out == '0 && closed_count == '0, "failed result carries data")

  `THA_ASSERT_IMPLY(a_alloc_only, clk, rst, out_valid && ok && handle_out != '0, object_out == '0 && closed_count == '0 && handle_out <= 7'(tha_pkg::SLOTS), "bad alloc result")

  `THA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(object_out), "stalled result dropped")

endmodule

bind typed_handle_allocator tha_checker u_tha_checker (.*);
